// ----- hw/rtl/bla_pkg.sv -----
// ----------------------------------------------------------------------------
// bla_pkg: battery level averager package
// Sizes, register indexes, controller states and the command/status
// structs shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package bla_pkg;

    // window and field sizes
    localparam int WINDOW    = 8;
    localparam int SAMPLE_W  = 12;
    localparam int MV_W      = 12;
    localparam int LEVEL_W   = 3;
    localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // millivolt scaling: mv = avg * SCALE_MV / 2^SAMPLE_W
    localparam int SCALE_MV  = 2500;
    localparam int SCALE_W   = 12;
    localparam int PROD_W    = SAMPLE_W + SCALE_W;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL4 = 8'd0,
        REG_LEVEL3 = 8'd1,
        REG_LEVEL2 = 8'd2,
        REG_LEVEL1 = 8'd3
    } reg_idx_t;

    localparam logic [MV_W-1:0] LEVEL4_RESET = 12'd1661;
    localparam logic [MV_W-1:0] LEVEL3_RESET = 12'd1591;
    localparam logic [MV_W-1:0] LEVEL2_RESET = 12'd1521;
    localparam logic [MV_W-1:0] LEVEL1_RESET = 12'd1451;

    // battery level codes
    localparam logic [LEVEL_W-1:0] LEVEL_NONE = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_TWO  = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_THR  = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_FOUR = 3'd4;

    // stream widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_UPDATE,
        ST_DIVIDE,
        ST_SCALE,
        ST_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;     // latch the incoming sample
        logic load;       // read the ring entry about to be replaced
        logic update;     // update ring, sum, count, index; start the divide
        logic div_step;   // one restoring divide step
        logic scale;      // multiply the mean by the millivolt scale
        logic finish;     // load the result register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_last;   // current divide step is the last one
        logic out_free;   // result register can take a new result
    } status_t;

endpackage

// ----- hw/rtl/bla_ctrl.sv -----
// ----------------------------------------------------------------------------
// bla_ctrl: battery level averager controller
// Sequences one request through ring update, divide, scaling and result load.
// ----------------------------------------------------------------------------
module bla_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  bla_pkg::status_t status,
    output bla_pkg::cmd_t    cmd
);

    bla_pkg::state_t state_reg;
    bla_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bla_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bla_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = bla_pkg::ST_LOAD;
                end
            end
            bla_pkg::ST_LOAD: begin
                state_next = bla_pkg::ST_UPDATE;
            end
            bla_pkg::ST_UPDATE: begin
                state_next = bla_pkg::ST_DIVIDE;
            end
            bla_pkg::ST_DIVIDE: begin
                if (status.div_last) begin
                    state_next = bla_pkg::ST_SCALE;
                end
            end
            bla_pkg::ST_SCALE: begin
                state_next = bla_pkg::ST_FINISH;
            end
            bla_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    state_next = bla_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bla_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_tready     = (state_reg == bla_pkg::ST_IDLE);
        cmd          = '0;
        cmd.accept   = (state_reg == bla_pkg::ST_IDLE) && s_tvalid;
        cmd.load     = (state_reg == bla_pkg::ST_LOAD);
        cmd.update   = (state_reg == bla_pkg::ST_UPDATE);
        cmd.div_step = (state_reg == bla_pkg::ST_DIVIDE);
        cmd.scale    = (state_reg == bla_pkg::ST_SCALE);
        cmd.finish   = (state_reg == bla_pkg::ST_FINISH) && status.out_free;
    end

endmodule

// ----- hw/rtl/bla_datapath.sv -----
// ----------------------------------------------------------------------------
// bla_datapath: battery level averager datapath
// Sample ring, running sum, bit-serial divider, millivolt scaling, level
// thresholds and the result register.
// ----------------------------------------------------------------------------
module bla_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bla_pkg::cmd_t                     cmd,
    output bla_pkg::status_t                  status,
    input  logic [bla_pkg::SAMPLE_W-1:0]      sample_in,
    input  logic                              cfg_valid,
    input  logic [bla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bla_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic                              res_valid,
    output logic [bla_pkg::SAMPLE_W-1:0]      res_average,
    output logic [bla_pkg::MV_W-1:0]          res_voltage,
    output logic [bla_pkg::LEVEL_W-1:0]       res_level
);

    localparam logic [bla_pkg::CNT_W-1:0] WIN_CNT  = bla_pkg::CNT_W'(bla_pkg::WINDOW);
    localparam logic [bla_pkg::IDX_W-1:0] IDX_LAST = bla_pkg::IDX_W'(bla_pkg::WINDOW - 1);
    localparam logic [bla_pkg::SCALE_W-1:0] SCALE_K = bla_pkg::SCALE_W'(bla_pkg::SCALE_MV);

    // thresholds
    logic [bla_pkg::MV_W-1:0] lvl4_reg, lvl3_reg, lvl2_reg, lvl1_reg;

    // ring and running state
    logic [bla_pkg::SAMPLE_W-1:0] ring [bla_pkg::WINDOW];
    logic [bla_pkg::SAMPLE_W-1:0] sample_reg;
    logic [bla_pkg::SAMPLE_W-1:0] old_reg;
    logic [bla_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [bla_pkg::CNT_W-1:0]    fill_reg, fill_next;
    logic [bla_pkg::IDX_W-1:0]    widx_reg, widx_next;
    logic                         full;

    // divider
    logic [bla_pkg::CNT_W-1:0]     divisor_reg;
    logic [bla_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [bla_pkg::SUM_W-1:0]     quo_reg, quo_next;
    logic [bla_pkg::DIV_CNT_W-1:0] dcnt_reg;
    logic [bla_pkg::CNT_W:0]       rem_shift;
    logic [bla_pkg::CNT_W:0]       rem_diff;

    // scaling and levels
    logic [bla_pkg::PROD_W-1:0]   prod_reg;
    logic [bla_pkg::SAMPLE_W-1:0] avg;
    logic [bla_pkg::MV_W-1:0]     mv;
    logic [bla_pkg::LEVEL_W-1:0]  level;

    // result register
    logic                         out_valid_reg;
    logic [bla_pkg::SAMPLE_W-1:0] out_avg_reg;
    logic [bla_pkg::MV_W-1:0]     out_mv_reg;
    logic [bla_pkg::LEVEL_W-1:0]  out_level_reg;

    // threshold register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl4_reg <= bla_pkg::LEVEL4_RESET;
            lvl3_reg <= bla_pkg::LEVEL3_RESET;
            lvl2_reg <= bla_pkg::LEVEL2_RESET;
            lvl1_reg <= bla_pkg::LEVEL1_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bla_pkg::REG_LEVEL4: lvl4_reg <= cfg_data;
                bla_pkg::REG_LEVEL3: lvl3_reg <= cfg_data;
                bla_pkg::REG_LEVEL2: lvl2_reg <= cfg_data;
                bla_pkg::REG_LEVEL1: lvl1_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // running state update
    always_comb begin
        full      = (fill_reg == WIN_CNT);
        fill_next = full ? WIN_CNT : fill_reg + 1'b1;
        widx_next = (widx_reg == IDX_LAST) ? '0 : widx_reg + 1'b1;
        sum_next  = sum_reg + bla_pkg::SUM_W'(sample_reg)
                  - (full ? bla_pkg::SUM_W'(old_reg) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            fill_reg <= '0;
            widx_reg <= '0;
        end else if (cmd.update) begin
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
            widx_reg <= widx_next;
        end
    end

    // sample capture and ring access
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= sample_in;
        end
        if (cmd.load) begin
            old_reg <= ring[widx_reg];
        end
        if (cmd.update) begin
            ring[widx_reg] <= sample_reg;
        end
    end

    // restoring divide step, one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg, quo_reg[bla_pkg::SUM_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        quo_next  = {quo_reg[bla_pkg::SUM_W-2:0], ~rem_diff[bla_pkg::CNT_W]};
        rem_next  = rem_diff[bla_pkg::CNT_W] ? rem_shift[bla_pkg::CNT_W-1:0]
                                             : rem_diff[bla_pkg::CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.update) begin
            dcnt_reg <= bla_pkg::DIV_CNT_W'(bla_pkg::SUM_W - 1);
        end else if (cmd.div_step && dcnt_reg != '0) begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            divisor_reg <= fill_next;
            rem_reg     <= '0;
            quo_reg     <= sum_next;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // millivolt scaling
    assign avg = quo_reg[bla_pkg::SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.scale) begin
            prod_reg <= bla_pkg::PROD_W'(avg) * bla_pkg::PROD_W'(SCALE_K);
        end
    end

    assign mv = prod_reg[bla_pkg::PROD_W-1:bla_pkg::SAMPLE_W];

    // threshold check, level four first
    always_comb begin
        priority if (mv >= lvl4_reg) begin
            level = bla_pkg::LEVEL_FOUR;
        end else if (mv >= lvl3_reg) begin
            level = bla_pkg::LEVEL_THR;
        end else if (mv >= lvl2_reg) begin
            level = bla_pkg::LEVEL_TWO;
        end else if (mv >= lvl1_reg) begin
            level = bla_pkg::LEVEL_ONE;
        end else begin
            level = bla_pkg::LEVEL_NONE;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_avg_reg   <= avg;
            out_mv_reg    <= mv;
            out_level_reg <= level;
        end
    end

    assign status.div_last = (dcnt_reg == '0);
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid    = out_valid_reg;
    assign res_valid   = 1'b1;
    assign res_average = out_avg_reg;
    assign res_voltage = out_mv_reg;
    assign res_level   = out_level_reg;

endmodule

// ----- hw/rtl/battery_level_averager.sv -----
// ----------------------------------------------------------------------------
// battery_level_averager: moving average of battery readings with levels
// Averages the last eight converter readings and reports the mean, the mean
// in millivolts and a battery level from four programmable thresholds.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one 12-bit converter reading per request, s_tdata[11:0].
//   m_ channel: one result per request; m_tdata holds average_raw [11:0],
//     voltage_mv [23:12], battery_level [26:24]; m_tuser[0] is valid_res.
//   cfg channel: cfg_index 0..3 selects level4..level1 minimum millivolts,
//     cfg_data[11:0] is written; other indexes are ignored. Always ready.
// Timing:
//   a request passes from accept through ring load, ring update, the
//   bit-serial divider by the fill count (one quotient bit per cycle),
//   scaling and result load. s_tready is high only while idle, and the
//   controller accepts in its first idle cycle, so it takes no new
//   request until the last one has reached the result register.
//   The result register lets the next request start while a result waits;
//   if m_tready stays low, the block holds its following result and stops
//   accepting until the register frees.
// Reset: aresetn low clears the sum, fill count, write index and result
//   valid, and restores the threshold defaults; ring contents are not cleared.
// ----------------------------------------------------------------------------
module battery_level_averager (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: adc_sample [11:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bla_pkg::S_DATA_W-1:0]      s_tdata,
    // m_tdata: average_raw [11:0], voltage_mv [23:12], battery_level [26:24]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bla_pkg::M_DATA_W-1:0]      m_tdata,
    // m_tuser: valid_res [0]
    output logic [0:0]                        m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bla_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bla_pkg::cmd_t    cmd;
    bla_pkg::status_t status;

    logic                         res_valid;
    logic [bla_pkg::SAMPLE_W-1:0] res_average;
    logic [bla_pkg::MV_W-1:0]     res_voltage;
    logic [bla_pkg::LEVEL_W-1:0]  res_level;

    // controller
    bla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    bla_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .sample_in   (s_tdata[bla_pkg::SAMPLE_W-1:0]),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .res_valid   (res_valid),
        .res_average (res_average),
        .res_voltage (res_voltage),
        .res_level   (res_level)
    );

    // result packing
    assign m_tdata = {
        {(bla_pkg::M_DATA_W - bla_pkg::SAMPLE_W - bla_pkg::MV_W - bla_pkg::LEVEL_W){1'b0}},
        res_level, res_voltage, res_average
    };
    assign m_tuser   = res_valid;
    assign cfg_ready = 1'b1;

endmodule

// ----- test/battery_level_averager_test.sv -----
// ----------------------------------------------------------------------------
// battery_level_averager_test: self-checking bench for the level averager
// Streams converter readings into the block, predicts the running mean,
// the millivolt value and the battery level for every request, and checks
// each result in order. Thresholds are reprogrammed between phases, both
// sides idle at random, and one long output stall fills the block up.
// ----------------------------------------------------------------------------
module battery_level_averager_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD    = 12;
    localparam int     RESET_CYCLES  = 6;
    localparam int     MAX_WAIT      = 5;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     PHASE_ITEMS   = 200;
    localparam int     MAX_REPORTS   = 10;
    localparam longint CYCLE_LIMIT   = 400000;

    // one averaged result
    typedef struct packed {
        logic                          valid_res;
        logic [bla_pkg::SAMPLE_W-1:0]  average_raw;
        logic [bla_pkg::MV_W-1:0]      voltage_mv;
        logic [bla_pkg::LEVEL_W-1:0]   battery_level;
    } level_report_t;

    // how a burst of random readings is drawn
    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_NEAR_LEVELS,
        SHAPE_STEADY,
        SHAPE_RAILS
    } sample_shape_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [bla_pkg::S_DATA_W-1:0]   s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [bla_pkg::M_DATA_W-1:0]   m_tdata;
    logic [0:0]                     m_tuser;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bla_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bla_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic [bla_pkg::SAMPLE_W-1:0] ring_copy [bla_pkg::WINDOW];
    logic [bla_pkg::MV_W-1:0]     level_min_copy [4];
    int unsigned                  sum_copy;
    int unsigned                  fill_copy;
    int unsigned                  slot_copy;

    level_report_t pending_reports [$];
    level_report_t seen_report;
    level_report_t want_report;

    bit     src_idle_en;
    bit     sink_idle_en;
    bit     sink_hold;
    int     mismatches;
    int     reports_checked;
    int     samples_sent;
    int     threshold_writes;
    longint cycle_count;

    battery_level_averager u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // run time limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_reports.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // store one reading and work out the mean, millivolts and level
    function automatic level_report_t next_battery_report(
        input logic [bla_pkg::SAMPLE_W-1:0] sample
    );
        int unsigned   mean;
        int unsigned   mv;
        level_report_t rep;
        if (fill_copy >= bla_pkg::WINDOW) begin
            sum_copy -= ring_copy[slot_copy];
        end else begin
            fill_copy++;
        end
        ring_copy[slot_copy] = sample;
        sum_copy += sample;
        slot_copy = (slot_copy + 1) % bla_pkg::WINDOW;
        mean = sum_copy / fill_copy;
        mv = (mean * bla_pkg::SCALE_MV) / (1 << bla_pkg::SAMPLE_W);
        rep.valid_res   = 1'b1;
        rep.average_raw = mean[bla_pkg::SAMPLE_W-1:0];
        rep.voltage_mv  = mv[bla_pkg::MV_W-1:0];
        // thresholds are tried from level four down, first hit wins
        if (mv >= level_min_copy[bla_pkg::REG_LEVEL4]) begin
            rep.battery_level = bla_pkg::LEVEL_FOUR;
        end else if (mv >= level_min_copy[bla_pkg::REG_LEVEL3]) begin
            rep.battery_level = bla_pkg::LEVEL_THR;
        end else if (mv >= level_min_copy[bla_pkg::REG_LEVEL2]) begin
            rep.battery_level = bla_pkg::LEVEL_TWO;
        end else if (mv >= level_min_copy[bla_pkg::REG_LEVEL1]) begin
            rep.battery_level = bla_pkg::LEVEL_ONE;
        end else begin
            rep.battery_level = bla_pkg::LEVEL_NONE;
        end
        return rep;
    endfunction

    // offer one reading, leaving tvalid high for a following request
    task automatic send_sample(input logic [bla_pkg::SAMPLE_W-1:0] sample);
        int gap;
        gap = src_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bla_pkg::S_DATA_W - bla_pkg::SAMPLE_W){1'b0}}, sample};
        do @(posedge aclk); while (!s_tready);
        pending_reports.push_back(next_battery_report(sample));
        samples_sent++;
    endtask

    // stop offering and let the block drain
    task automatic finish_burst();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one register write, only called while the block is idle
    task automatic write_threshold(input logic [bla_pkg::CFG_IDX_W-1:0] index,
                                   input logic [bla_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index <= bla_pkg::REG_LEVEL1) begin
            level_min_copy[index[1:0]] = value;
        end
        threshold_writes++;
        @(posedge aclk);
    endtask

    task automatic write_levels(input logic [bla_pkg::MV_W-1:0] lvl4,
                                input logic [bla_pkg::MV_W-1:0] lvl3,
                                input logic [bla_pkg::MV_W-1:0] lvl2,
                                input logic [bla_pkg::MV_W-1:0] lvl1);
        write_threshold(bla_pkg::REG_LEVEL4, lvl4);
        write_threshold(bla_pkg::REG_LEVEL3, lvl3);
        write_threshold(bla_pkg::REG_LEVEL2, lvl2);
        write_threshold(bla_pkg::REG_LEVEL1, lvl1);
    endtask

    // ring filling from reset, rail values, then wrap-around
    task automatic test_fill_ring();
        logic [bla_pkg::SAMPLE_W-1:0] fill_values [10];
        fill_values = '{12'hFFF, 12'h000, 12'hFFF, 12'h001, 12'h800,
                        12'hFFE, 12'h007, 12'hFFF, 12'hAAA, 12'h555};
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        foreach (fill_values[i]) send_sample(fill_values[i]);
        finish_burst();
    endtask

    // full ring settling exactly on the default level four boundary
    task automatic test_level_boundary();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (bla_pkg::WINDOW) send_sample(12'd2722);
        finish_burst();
    endtask

    // writes to indexes past level one must not land anywhere
    task automatic test_ignored_index();
        write_threshold(8'd4, 12'hFFF);
        write_threshold(8'hFF, 12'hFFF);
        send_sample(12'd2722);
        finish_burst();
    endtask

    // random readings in bursts of different shapes
    task automatic test_random_samples(input int count);
        int                           sent;
        int                           burst;
        sample_shape_t                shape;
        logic [bla_pkg::SAMPLE_W-1:0] base;
        logic [bla_pkg::SAMPLE_W-1:0] sample;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            shape = sample_shape_t'($urandom_range(0, 3));
            base  = bla_pkg::SAMPLE_W'($urandom_range(0, 4095));
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < burst && sent < count; i++) begin
                unique case (shape)
                    SHAPE_UNIFORM: begin
                        sample = bla_pkg::SAMPLE_W'($urandom_range(0, 4095));
                    end
                    SHAPE_NEAR_LEVELS: begin
                        sample = bla_pkg::SAMPLE_W'($urandom_range(2300, 2800));
                    end
                    SHAPE_STEADY: begin
                        sample = base;
                    end
                    default: begin
                        sample = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                    end
                endcase
                send_sample(sample);
                sent++;
            end
        end
        finish_burst();
    endtask

    // long output stall while readings keep coming
    task automatic test_output_stall();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        sink_hold    = 1'b1;
        repeat (12) send_sample(bla_pkg::SAMPLE_W'($urandom_range(0, 4095)));
        finish_burst();
    endtask

    // result side ready pattern
    initial begin
        int wait_cycles;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (sink_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                sink_hold = 1'b0;
            end else begin
                wait_cycles = sink_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
                if (wait_cycles > 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_cycles) @(posedge aclk);
                end
                m_tready <= 1'b1;
                do @(posedge aclk); while (!m_tvalid);
            end
        end
    end

    // compare each result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_report.valid_res     = m_tuser[0];
            seen_report.average_raw   = m_tdata[11:0];
            seen_report.voltage_mv    = m_tdata[23:12];
            seen_report.battery_level = m_tdata[26:24];
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result avg %0d mv %0d level %0d",
                             seen_report.average_raw, seen_report.voltage_mv,
                             seen_report.battery_level);
                end
            end else begin
                want_report = pending_reports.pop_front();
                reports_checked++;
                if (seen_report.valid_res !== want_report.valid_res ||
                    seen_report.average_raw !== want_report.average_raw ||
                    seen_report.voltage_mv !== want_report.voltage_mv ||
                    seen_report.battery_level !== want_report.battery_level) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 reports_checked, want_report.valid_res,
                                 want_report.average_raw, want_report.voltage_mv,
                                 want_report.battery_level, seen_report.valid_res,
                                 seen_report.average_raw, seen_report.voltage_mv,
                                 seen_report.battery_level);
                    end
                end
            end
        end
    end

    // test sequence
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sink_hold = 1'b0;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        level_min_copy[bla_pkg::REG_LEVEL4] = bla_pkg::LEVEL4_RESET;
        level_min_copy[bla_pkg::REG_LEVEL3] = bla_pkg::LEVEL3_RESET;
        level_min_copy[bla_pkg::REG_LEVEL2] = bla_pkg::LEVEL2_RESET;
        level_min_copy[bla_pkg::REG_LEVEL1] = bla_pkg::LEVEL1_RESET;
        foreach (ring_copy[i]) ring_copy[i] = '0;
        sum_copy  = 0;
        fill_copy = 0;
        slot_copy = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill_ring();
        test_level_boundary();
        test_ignored_index();

        // thresholds from reset
        test_random_samples(PHASE_ITEMS);
        // every level at zero: always level four
        write_levels(12'd0, 12'd0, 12'd0, 12'd0);
        test_random_samples(PHASE_ITEMS / 2);
        // all above reach: never any level
        write_levels(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        test_random_samples(PHASE_ITEMS / 2);
        // reversed order
        write_levels(12'd1000, 12'd1400, 12'd1800, 12'd2200);
        test_random_samples(PHASE_ITEMS);
        test_output_stall();
        // random thresholds across the whole register range
        repeat (4) begin
            write_levels(bla_pkg::MV_W'($urandom_range(0, 4095)),
                         bla_pkg::MV_W'($urandom_range(0, 4095)),
                         bla_pkg::MV_W'($urandom_range(0, 4095)),
                         bla_pkg::MV_W'($urandom_range(0, 4095)));
            test_random_samples(PHASE_ITEMS / 4);
        end
        // back to defaults
        write_levels(bla_pkg::LEVEL4_RESET, bla_pkg::LEVEL3_RESET,
                     bla_pkg::LEVEL2_RESET, bla_pkg::LEVEL1_RESET);
        test_random_samples(PHASE_ITEMS);

        if (pending_reports.size() != 0) begin
            mismatches++;
        end
        $display("checked %0d averaged results from %0d readings, %0d mismatches",
                 reports_checked, samples_sent, mismatches);
        $display("covered ring fill and wrap, rail readings, %0d threshold writes %s",
                 threshold_writes, "incl. ignored indexes, and a long output stall");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
